/* design/lrut_pkg.sv */
package lrut_pkg;

    localparam int PAGE_KEY_W  = 32;
    localparam int EV_KEY_W    = 32;
    localparam int CAP_W       = 5;
    localparam int DEPTH_DEF   = 16;
    localparam int KEY_W_DEF   = 32;

    typedef struct packed {
        logic upd;
        logic ins;
    } lrut_ctl_t;

endpackage

/* design/lrut_cell.sv */
module lrut_cell
    import lrut_pkg::*;
#(
    parameter int KW  = KEY_W_DEF,
    parameter int CW  = CAP_W,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  lrut_ctl_t     ctl,
    input  logic [KW-1:0] key_in,
    input  logic [CW-1:0] cap_eff,
    input  logic [KW-1:0] up_key,
    input  logic          up_valid,
    input  logic          dn_valid,
    input  logic          sh_in,
    output logic [KW-1:0] key_q,
    output logic          valid_q,
    output logic          match,
    output logic          sh_out,
    output logic          at_cap
);

    localparam logic [CW-1:0] POS = CW'(IDX + 1);

    logic [KW-1:0] key_reg;
    logic [KW-1:0] key_next;
    logic          valid_reg;
    logic          valid_next;
    logic          tail;
    logic          free;

    assign match   = valid_reg && (key_reg == key_in);
    assign sh_out  = sh_in || match;
    assign at_cap  = valid_reg && (POS >= cap_eff);
    assign tail    = valid_reg && !up_valid;
    assign free    = !valid_reg && dn_valid;
    assign key_q   = key_reg;
    assign valid_q = valid_reg;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctl.upd)
        begin
            if (sh_out && valid_reg)
            begin
                key_next = tail ? key_in : up_key;
            end
            else if (free && ctl.ins)
            begin
                key_next   = key_in;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

/* design/lru_page_reference_tracker.sv */
// Result: each result beat is registered and shown in the cycle after its page key is accepted.
// Throughput: one key per cycle unless the output stalls; match, shift and insert all settle in
// the cell row within the accepting cycle, and the output register holds a stalled result.
// Reset: asynchronous, active low; all entries invalid, capacity set to DEPTH,
// no result pending. No clearing pass is needed.
module lru_page_reference_tracker
    import lrut_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_W_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CAP_W-1:0]      cfg_data,      // capacity
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PAGE_KEY_W-1:0] s_axis_tdata,  // page_key
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [EV_KEY_W-1:0]   m_axis_tdata,  // evicted_key
    output logic [1:0]            m_axis_tuser   // hit, evicted
);

    localparam int DW   = $clog2(DEPTH + 1);
    localparam int CW   = (DW > CAP_W) ? DW : CAP_W;
    localparam int KIN  = (KEY_WIDTH < PAGE_KEY_W) ? KEY_WIDTH : PAGE_KEY_W;
    localparam int KOUT = (KEY_WIDTH < EV_KEY_W) ? KEY_WIDTH : EV_KEY_W;

    logic [CW-1:0]        cap_reg;
    logic [CW-1:0]        cap_next;
    logic [CW-1:0]        cap_eff;
    logic [KEY_WIDTH-1:0] key_in;
    logic [KEY_WIDTH-1:0] key_q [DEPTH];
    logic [DEPTH-1:0]     valid_q;
    logic [DEPTH-1:0]     match;
    logic [DEPTH-1:0]     at_cap;
    logic [DEPTH-1:0]     sh;
    logic                 accept;
    logic                 hit;
    logic                 evict;
    lrut_ctl_t            ctl;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic                 ev_reg;
    logic                 ev_next;
    logic [EV_KEY_W-1:0]  evk_reg;
    logic [EV_KEY_W-1:0]  evk_next;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        key_in            = '0;
        key_in[KIN-1:0]   = s_axis_tdata[KIN-1:0];
    end

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_valid)
        begin
            cap_next = CW'(cfg_data);
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (cap_reg > CW'(DEPTH))
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign hit     = |match;
    assign evict   = !hit && |at_cap;
    assign sh[0]   = evict;
    assign ctl.upd = accept;
    assign ctl.ins = !hit && !evict;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] up_key;
        logic                 up_valid;
        logic                 dn_valid;
        logic                 sh_out;

        if (i == DEPTH - 1)
        begin : g_top
            assign up_key   = '0;
            assign up_valid = 1'b0;
        end
        else
        begin : g_mid
            assign up_key   = key_q[i+1];
            assign up_valid = valid_q[i+1];
            assign sh[i+1]  = sh_out;
        end

        if (i == 0)
        begin : g_bot
            assign dn_valid = 1'b1;
        end
        else
        begin : g_up
            assign dn_valid = valid_q[i-1];
        end

        lrut_cell #(
            .KW  (KEY_WIDTH),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .key_in   (key_in),
            .cap_eff  (cap_eff),
            .up_key   (up_key),
            .up_valid (up_valid),
            .dn_valid (dn_valid),
            .sh_in    (sh[i]),
            .key_q    (key_q[i]),
            .valid_q  (valid_q[i]),
            .match    (match[i]),
            .sh_out   (sh_out),
            .at_cap   (at_cap[i])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        ev_next        = ev_reg;
        evk_next       = evk_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            hit_next       = hit;
            ev_next        = evict;
            evk_next       = '0;
            if (evict)
            begin
                evk_next[KOUT-1:0] = key_q[0][KOUT-1:0];
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CW'(DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        ev_reg  <= ev_next;
        evk_reg <= evk_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = evk_reg;
    assign m_axis_tuser  = {ev_reg, hit_reg};

endmodule

/* design/lrut_chk.sv */
module lrut_chk
    import lrut_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [EV_KEY_W-1:0] m_axis_tdata,
    input logic [1:0]          m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("hit and eviction in one beat");

    a_evk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata == '0))
        else $error("evicted key not zero without eviction");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("no result beat after accepted key");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

endmodule

bind lru_page_reference_tracker lrut_chk u_lrut_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* sim/lru_reference_checker.sv */
`timescale 1ns / 1ps
module lru_reference_checker
    import lrut_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CAP_W-1:0]      cfg_data,      // capacity
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [PAGE_KEY_W-1:0] s_axis_tdata,  // page_key
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [EV_KEY_W-1:0]   m_axis_tdata,  // evicted_key
    input  logic [1:0]            m_axis_tuser,  // hit, evicted
    output int                    pending,
    output int                    failures
);

    typedef struct packed {
        logic                hit;
        logic                evicted;
        logic [EV_KEY_W-1:0] evicted_key;
    } lru_outcome_t;

    logic [PAGE_KEY_W-1:0] frame_key [DEPTH];
    int                    held;
    logic [CAP_W-1:0]      capacity;
    lru_outcome_t          outcome_q [$];

    // remove one frame, later frames shift towards the oldest end
    function automatic void drop_frame(int pos);
        for (int i = pos; i < held - 1; i++)
            frame_key[i] = frame_key[i + 1];
        held--;
    endfunction

    function automatic lru_outcome_t touch_page(logic [PAGE_KEY_W-1:0] key);
        lru_outcome_t o;
        int           pos;
        int           lim;
        o   = '0;
        pos = -1;
        for (int i = 0; i < held; i++)
            if (pos < 0 && frame_key[i] == key)
                pos = i;
        if (capacity == 0)
            lim = 1;
        else if (capacity > DEPTH)
            lim = DEPTH;
        else
            lim = capacity;
        if (pos >= 0)
        begin
            o.hit = 1'b1;
            drop_frame(pos);
        end
        else if (held >= lim)
        begin
            o.evicted     = 1'b1;
            o.evicted_key = frame_key[0];
            drop_frame(0);
        end
        if (held < DEPTH)
        begin
            frame_key[held] = key;
            held++;
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lru_outcome_t want;
        int           errs;
        if (!rst_n)
        begin
            held     = 0;
            capacity = CAP_W'(DEPTH);
            outcome_q.delete();
            pending  <= 0;
            failures <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result beat with no page reference waiting: tdata %08h tuser %02b",
                           m_axis_tdata, m_axis_tuser);
                    errs++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (m_axis_tuser[0] !== want.hit)
                    begin
                        $error("hit: expected %0b, got %0b", want.hit, m_axis_tuser[0]);
                        errs++;
                    end
                    if (m_axis_tuser[1] !== want.evicted)
                    begin
                        $error("evicted: expected %0b, got %0b", want.evicted, m_axis_tuser[1]);
                        errs++;
                    end
                    if (m_axis_tdata !== want.evicted_key)
                    begin
                        $error("evicted_key: expected %08h, got %08h",
                               want.evicted_key, m_axis_tdata);
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                outcome_q.push_back(touch_page(s_axis_tdata));
            pending  <= outcome_q.size();
            failures <= failures + errs;
        end
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import lrut_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int PHASES    = 10;
    localparam int PHASE_LEN = 152;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CAP_W-1:0]      cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PAGE_KEY_W-1:0] s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [EV_KEY_W-1:0]   m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int                    pending;
    int                    failures;
    int                    cycles;
    logic                  no_idle;
    logic [PAGE_KEY_W-1:0] key_pool [32];
    int                    pool_n;
    logic [CAP_W-1:0]      phase_cap [PHASES];

    lru_page_reference_tracker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lru_reference_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .pending       (pending),
        .failures      (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("lru_page_reference_tracker: mismatch");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_key(input logic [PAGE_KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // hold the sender until every result beat has drained
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_pool(input int frames);
        pool_n = frames + $urandom_range(0, frames / 2 + 2);
        if (pool_n > 32)
            pool_n = 32;
        for (int i = 0; i < pool_n; i++)
            if (i > 0 && $urandom_range(0, 3) == 0)
                key_pool[i] = key_pool[$urandom_range(0, i - 1)] ^
                              (PAGE_KEY_W'(1) << $urandom_range(0, PAGE_KEY_W - 1));
            else
                key_pool[i] = $urandom();
    endtask

    // receiver: short random stalls, plus a long hold now and then
    initial
    begin
        int stall;
        int beats;
        int next_hold;
        stall     = 0;
        beats     = 0;
        next_hold = 300;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                beats++;
            if (stall == 0 && beats >= next_hold)
            begin
                stall     = 80;
                next_hold = next_hold + 700;
            end
            else if (stall == 0 && $urandom_range(0, 3) == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int                    frames;
        int                    mode;
        int                    scan;
        int                    r;
        logic [PAGE_KEY_W-1:0] k;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        no_idle       <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full capacity out of reset: sole entry, newest and oldest hits, then fill and evict
        send_key('0);
        send_key('0);
        send_key('1);
        send_key('1);
        send_key('0);
        for (int i = 1; i <= 14; i++)
            send_key(PAGE_KEY_W'(i));
        send_key(32'h8000_0001);
        send_key('0);

        // capacity lowered below occupancy
        wait_idle();
        write_capacity(5'd2);
        send_key(32'hA5A5_A5A5);
        send_key(32'd14);
        // capacity zero acts as one
        wait_idle();
        write_capacity(5'd0);
        send_key(32'h5A5A_5A5A);

        phase_cap = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd5, 5'd8, 5'd2, 5'd20, 5'd15};
        phase_cap[5] = CAP_W'($urandom_range(2, 15));
        phase_cap[8] = CAP_W'($urandom_range(17, 31));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            write_capacity(phase_cap[ph]);
            no_idle <= (ph % 4 == 3);
            if (phase_cap[ph] == 0)
                frames = 1;
            else if (phase_cap[ph] > DEPTH_DEF)
                frames = DEPTH_DEF;
            else
                frames = phase_cap[ph];
            fill_pool(frames);
            mode = $urandom_range(0, 2);
            scan = 0;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                begin
                    if (mode == 1)
                    begin
                        k    = key_pool[scan];
                        scan = (scan + 1) % pool_n;
                    end
                    else
                        k = key_pool[$urandom_range(0, pool_n - 1)];
                end
                else if (r < 95)
                    k = $urandom();
                else if (r < 97)
                    k = '0;
                else
                    k = '1;
                send_key(k);
            end
        end

        wait_idle();
        if (failures == 0)
            $display("lru_page_reference_tracker: match");
        else
            $display("lru_page_reference_tracker: mismatch");
        $finish;
    end

endmodule

/* files.f */
design/lrut_pkg.sv
design/lrut_cell.sv
design/lru_page_reference_tracker.sv
design/lrut_chk.sv
sim/lru_reference_checker.sv
sim/tb_top.sv
